/* rtl/tfve_pkg.sv */
// Shared types and constants for the tagged field varint encoder.
// No dependencies; imported by every module of the block.
package tfve_pkg;

    // Field widths
    localparam int FIELD_W = 16;
    localparam int VALUE_W = 64;
    localparam int KIND_W  = 3;
    localparam int WIRE_W  = 3;
    localparam int TAG_W   = FIELD_W + WIRE_W;
    localparam int CNT_W   = 4;

    // Value kinds
    localparam logic [KIND_W-1:0] KIND_INT32  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INT64  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BOOL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FLOAT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 3'd4;

    // Wire codes placed in the low three tag bits
    localparam logic [WIRE_W-1:0] WIRE_ZERO  = 3'd0;
    localparam logic [WIRE_W-1:0] WIRE_ONE   = 3'd1;
    localparam logic [WIRE_W-1:0] WIRE_NEG   = 3'd2;
    localparam logic [WIRE_W-1:0] WIRE_POS   = 3'd3;
    localparam logic [WIRE_W-1:0] WIRE_FIXED = 3'd5;

    // Bit patterns of 1.0
    localparam logic [31:0]      FLOAT_ONE_BITS  = 32'h3F80_0000;
    localparam logic [VALUE_W-1:0] DOUBLE_ONE_BITS = 64'h3FF0_0000_0000_0000;

    // Body formats following the tag
    typedef logic [1:0] body_mode_t;
    localparam body_mode_t BODY_NONE   = 2'd0;
    localparam body_mode_t BODY_VARINT = 2'd1;
    localparam body_mode_t BODY_RAW4   = 2'd2;
    localparam body_mode_t BODY_RAW8   = 2'd3;

    localparam logic [CNT_W-1:0] RAW4_BYTES = 4'd4;
    localparam logic [CNT_W-1:0] RAW8_BYTES = 4'd8;

    // One classified item, as queued between front and back
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        body_mode_t         mode;
        logic [VALUE_W-1:0] body;
    } entry_t;

endpackage

/* rtl/tfve_classify.sv */
// Front end: decodes kind and value into a tag and a body description.
// Depends on tfve_pkg; feeds tfve_queue.
module tfve_classify import tfve_pkg::*; (
    input  logic [KIND_W-1:0]  req_type,
    input  logic [FIELD_W-1:0] field_number,
    input  logic [VALUE_W-1:0] value_bits,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               q_valid,
    input  logic               q_ready,
    output entry_t             q_entry
);

    logic [31:0]        v32;
    logic [WIRE_W-1:0]  wire_code;
    body_mode_t         mode;
    logic [VALUE_W-1:0] body;
    logic               kind_ok;

    assign v32 = value_bits[31:0];

    // Per-kind wire code and body selection
    always_comb begin
        wire_code = WIRE_ZERO;
        mode      = BODY_NONE;
        body      = value_bits;
        kind_ok   = 1'b1;
        unique case (req_type)
            KIND_INT32: begin
                if (v32 == 32'd0) begin
                    wire_code = WIRE_ZERO;
                end else if (v32 == 32'd1) begin
                    wire_code = WIRE_ONE;
                end else if (v32[31]) begin
                    wire_code = WIRE_NEG;
                    mode      = BODY_VARINT;
                    body      = {32'd0, ~{v32[30:0], 1'b0}};
                end else begin
                    wire_code = WIRE_POS;
                    mode      = BODY_VARINT;
                    body      = {32'd0, v32};
                end
            end
            KIND_INT64: begin
                if (value_bits == 64'd0) begin
                    wire_code = WIRE_ZERO;
                end else if (value_bits == 64'd1) begin
                    wire_code = WIRE_ONE;
                end else if (value_bits[VALUE_W-1]) begin
                    wire_code = WIRE_NEG;
                    mode      = BODY_VARINT;
                    body      = ~{value_bits[VALUE_W-2:0], 1'b0};
                end else begin
                    wire_code = WIRE_POS;
                    mode      = BODY_VARINT;
                end
            end
            KIND_BOOL: begin
                wire_code = (|value_bits) ? WIRE_ONE : WIRE_ZERO;
            end
            KIND_FLOAT: begin
                if (v32[30:0] == 31'd0) begin
                    wire_code = WIRE_ZERO;
                end else if (v32 == FLOAT_ONE_BITS) begin
                    wire_code = WIRE_ONE;
                end else begin
                    wire_code = WIRE_FIXED;
                    mode      = BODY_RAW4;
                    body      = {32'd0, v32};
                end
            end
            KIND_DOUBLE: begin
                if (value_bits[VALUE_W-2:0] == 63'd0) begin
                    wire_code = WIRE_ZERO;
                end else if (value_bits == DOUBLE_ONE_BITS) begin
                    wire_code = WIRE_ONE;
                end else begin
                    wire_code = WIRE_FIXED;
                    mode      = BODY_RAW8;
                end
            end
            default: begin
                // unused kinds are taken and dropped
                kind_ok = 1'b0;
            end
        endcase
    end

    // Unused kinds are accepted but never queued
    assign in_ready      = q_ready;
    assign q_valid       = in_valid && kind_ok;
    assign q_entry.tag   = {field_number, wire_code};
    assign q_entry.mode  = mode;
    assign q_entry.body  = body;

endmodule

/* rtl/tfve_queue.sv */
// Short FIFO of classified items between front end and serializer.
// Depends on tfve_pkg for the entry type.
module tfve_queue import tfve_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  entry_t in_entry,
    output logic   out_valid,
    input  logic   out_ready,
    output entry_t out_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    logic               push, pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_entry = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    // Fill count stays within depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

/* rtl/tfve_serializer.sv */
// Back end: turns one queued item into tag and body bytes, one per cycle unless m_ready stalls.
// Depends on tfve_pkg; drives the registered result channel.
module tfve_serializer import tfve_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  entry_t     q_entry,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_byte
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TAG  = 2'd1;
    localparam logic [1:0] ST_BODY = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [VALUE_W-1:0] body_reg, body_next;
    body_mode_t         mode_reg, mode_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_out_byte_reg, m_out_byte_next;
    logic               m_last_byte_reg, m_last_byte_next;

    logic       tag_more, body_more, is_raw;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       emit, done;

    assign tag_more  = |tag_reg[TAG_W-1:7];
    assign body_more = |body_reg[VALUE_W-1:7];
    assign is_raw    = (mode_reg == BODY_RAW4) || (mode_reg == BODY_RAW8);

    // Byte at the head of the current item
    always_comb begin
        cur_byte = 8'd0;
        cur_last = 1'b0;
        unique case (state_reg)
            ST_TAG: begin
                cur_byte = {tag_more, tag_reg[6:0]};
                cur_last = !tag_more && (mode_reg == BODY_NONE);
            end
            ST_BODY: begin
                if (is_raw) begin
                    cur_byte = body_reg[7:0];
                    cur_last = (cnt_reg == CNT_W'(1));
                end else begin
                    cur_byte = {body_more, body_reg[6:0]};
                    cur_last = !body_more;
                end
            end
            default: begin
                cur_byte = 8'd0;
                cur_last = 1'b0;
            end
        endcase
    end

    assign emit    = (state_reg != ST_IDLE) && (!m_valid_reg || m_ready);
    assign done    = emit && cur_last;
    assign q_ready = (state_reg == ST_IDLE) || done;

    // Sequencing through tag and body, with next item loaded on the last byte or while idle
    always_comb begin
        state_next       = state_reg;
        tag_next         = tag_reg;
        body_next        = body_reg;
        mode_next        = mode_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_out_byte_next  = m_out_byte_reg;
        m_last_byte_next = m_last_byte_reg;

        if (emit) begin
            m_valid_next     = 1'b1;
            m_out_byte_next  = cur_byte;
            m_last_byte_next = cur_last;
            if (state_reg == ST_TAG) begin
                if (tag_more) begin
                    tag_next = tag_reg >> 7;
                end else begin
                    state_next = ST_BODY;
                end
            end else if (is_raw) begin
                body_next = body_reg >> 8;
                cnt_next  = cnt_reg - 1'b1;
            end else begin
                body_next = body_reg >> 7;
            end
            if (cur_last) begin
                state_next = ST_IDLE;
            end
        end

        if (q_valid && q_ready) begin
            state_next = ST_TAG;
            tag_next   = q_entry.tag;
            body_next  = q_entry.body;
            mode_next  = q_entry.mode;
            cnt_next   = (q_entry.mode == BODY_RAW8) ? RAW8_BYTES : RAW4_BYTES;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        tag_reg         <= tag_next;
        body_reg        <= body_next;
        mode_reg        <= mode_next;
        cnt_reg         <= cnt_next;
        m_out_byte_reg  <= m_out_byte_next;
        m_last_byte_reg <= m_last_byte_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_last_byte = m_last_byte_reg;

    // Raw body never runs out of bytes before its last one
    a_raw_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BODY && is_raw) |-> (cnt_reg != '0))
        else $error("raw body count underflow");

    // Finishing with nothing queued returns to idle
    a_idle_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && !q_valid) |=> (state_reg == ST_IDLE))
        else $error("serializer did not go idle");

    // Every emitted byte lands in the output register
    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (m_valid_reg && m_out_byte_reg == $past(cur_byte)))
        else $error("emitted byte not registered");

    // No body phase for an item without a body
    a_body_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BODY) |-> (mode_reg != BODY_NONE))
        else $error("body phase without body");

endmodule

/* rtl/tagged_field_varint_encoder.sv */
// Top level of the tagged field varint encoder: classify, queue, serialize.
// Depends on tfve_pkg, tfve_classify, tfve_queue and tfve_serializer.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+--------------------------------------
//  s_      | in        | s_valid / s_ready | s_req_type, s_field_number, s_value_bits
//  m_      | out       | m_valid / m_ready | m_out_byte, m_last_byte (last byte of item)
//
// One result byte per cycle while not stalled; an item gives its tag bytes
// (1 to 3) plus body bytes (0, 4, 8 or up to 10), set by the single serializer.
// Items with unused kinds are accepted and give no bytes.
// Reset (aresetn low, synchronous) empties the queue and the output register.
// The front accepts while the queue has room, so it keeps taking items while
// the output is stalled; the next item's first byte follows the last byte
// of the previous item without a gap when it is already queued.
module tagged_field_varint_encoder import tfve_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [KIND_W-1:0]  s_req_type,
    input  logic [FIELD_W-1:0] s_field_number,
    input  logic [VALUE_W-1:0] s_value_bits,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last_byte
);

    logic   push_valid, push_ready;
    entry_t push_entry;
    logic   pop_valid, pop_ready;
    entry_t pop_entry;

    // Front: classify items
    tfve_classify u_classify (
        .req_type     (s_req_type),
        .field_number (s_field_number),
        .value_bits   (s_value_bits),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .q_valid      (push_valid),
        .q_ready      (push_ready),
        .q_entry      (push_entry)
    );

    // Decoupling queue
    tfve_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_entry (pop_entry)
    );

    // Back: byte serializer
    tfve_serializer u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_valid),
        .q_ready     (pop_ready),
        .q_entry     (pop_entry),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for tagged_field_varint_encoder: directed and random items
// under several idle and stall mixes, each output byte checked against an in-bench encoder.
// Depends on tfve_pkg and the tagged_field_varint_encoder RTL.
module tb_top;
    import tfve_pkg::*;

    // One expected output byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } enc_byte_t;

    // One input item waiting to be driven
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] field;
        logic [VALUE_W-1:0] value;
    } field_item_t;

    localparam int RANDOM_ITEMS = 160;
    localparam int DRAIN_CYCLES = 40;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [KIND_W-1:0]  s_req_type = '0;
    logic [FIELD_W-1:0] s_field_number = '0;
    logic [VALUE_W-1:0] s_value_bits = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_out_byte;
    logic               m_last_byte;

    field_item_t pending_items[$];
    enc_byte_t   expected_bytes[$];
    int          items_issued = 0;
    int          items_taken = 0;
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    tagged_field_varint_encoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_field_number (s_field_number),
        .s_value_bits   (s_value_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_byte    (m_last_byte)
    );

    always #4 aclk = ~aclk;

    // Encoder model: varint groups low first, continuation bit on all but the last
    function automatic void push_varint(input logic [63:0] v);
        while (v >= 64'h80) begin
            expected_bytes.push_back('{data: {1'b1, v[6:0]}, last: 1'b0});
            v = v >> 7;
        end
        expected_bytes.push_back('{data: v[7:0], last: 1'b0});
    endfunction

    // Fixed-width body, least significant byte first
    function automatic void push_raw(input logic [63:0] v, input int count);
        for (int i = 0; i < count; i++) begin
            expected_bytes.push_back('{data: v[7:0], last: 1'b0});
            v = v >> 8;
        end
    endfunction

    function automatic void push_tag(input logic [FIELD_W-1:0] field,
                                     input logic [WIRE_W-1:0] wire_code);
        logic [TAG_W-1:0] tag;
        tag = {field, wire_code};
        push_varint(64'(tag));
    endfunction

    // Appends the byte stream that one accepted item should produce
    function automatic void encode_field(input logic [KIND_W-1:0] kind,
                                         input logic [FIELD_W-1:0] field,
                                         input logic [VALUE_W-1:0] value);
        int          start;
        logic [63:0] v;
        logic        neg;
        start = expected_bytes.size();
        case (kind)
            KIND_INT32, KIND_INT64: begin
                if (kind == KIND_INT32) begin
                    v   = {32'd0, value[31:0]};
                    neg = value[31];
                end else begin
                    v   = value;
                    neg = value[63];
                end
                if (v == 64'd0) begin
                    push_tag(field, WIRE_ZERO);
                end else if (v == 64'd1) begin
                    push_tag(field, WIRE_ONE);
                end else if (neg) begin
                    // zigzag of a negative value: shift left, invert at the kind's width
                    push_tag(field, WIRE_NEG);
                    if (kind == KIND_INT32)
                        push_varint({32'd0, (v[31:0] << 1) ^ 32'hFFFF_FFFF});
                    else
                        push_varint((v << 1) ^ 64'hFFFF_FFFF_FFFF_FFFF);
                end else begin
                    push_tag(field, WIRE_POS);
                    push_varint(v);
                end
            end
            KIND_BOOL: begin
                push_tag(field, (value != '0) ? WIRE_ONE : WIRE_ZERO);
            end
            KIND_FLOAT: begin
                if (value[30:0] == '0)
                    push_tag(field, WIRE_ZERO);
                else if (value[31:0] == FLOAT_ONE_BITS)
                    push_tag(field, WIRE_ONE);
                else begin
                    push_tag(field, WIRE_FIXED);
                    push_raw({32'd0, value[31:0]}, int'(RAW4_BYTES));
                end
            end
            KIND_DOUBLE: begin
                if (value[62:0] == '0)
                    push_tag(field, WIRE_ZERO);
                else if (value == DOUBLE_ONE_BITS)
                    push_tag(field, WIRE_ONE);
                else begin
                    push_tag(field, WIRE_FIXED);
                    push_raw(value, int'(RAW8_BYTES));
                end
            end
            default: ;  // unused kinds give no bytes
        endcase
        if (expected_bytes.size() > start)
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    // Driver: presents the next pending item once the previous one is taken
    always @(posedge aclk) begin : drive_proc
        field_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending_items.pop_front();
                s_valid        <= 1'b1;
                s_req_type     <= it.kind;
                s_field_number <= it.field;
                s_value_bits   <= it.value;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predicts on input accept, then checks any output byte taken
    always @(posedge aclk) begin : monitor_proc
        enc_byte_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                encode_field(s_req_type, s_field_number, s_value_bits);
                items_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte: m_out_byte %h, m_last_byte %b",
                           m_out_byte, m_last_byte);
                    error_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_out_byte !== want.data) begin
                        $error("m_out_byte: expected %h, got %h", want.data, m_out_byte);
                        error_count++;
                    end
                    if (m_last_byte !== want.last) begin
                        $error("m_last_byte: expected %b, got %b", want.last, m_last_byte);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic add_item(input logic [KIND_W-1:0] kind,
                            input logic [FIELD_W-1:0] field,
                            input logic [VALUE_W-1:0] value);
        pending_items.push_back('{kind: kind, field: field, value: value});
        items_issued++;
    endtask

    // Random value with a random significant length so varint sizes spread out
    function automatic logic [63:0] rand_bits(input int len);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (len < 64)
            v = v & ((64'd1 << len) - 64'd1);
        return v;
    endfunction

    task automatic add_random_item();
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] field;
        logic [VALUE_W-1:0] value;
        int                 pick;
        // mostly valid kinds, a few unused ones
        if ($urandom_range(99) < 8)
            kind = KIND_W'($urandom_range(int'(KIND_DOUBLE) + 1, (1 << KIND_W) - 1));
        else
            kind = KIND_W'($urandom_range(int'(KIND_INT32), int'(KIND_DOUBLE)));
        case ($urandom_range(3))
            0:       field = FIELD_W'($urandom_range(0, 15));
            1:       field = FIELD_W'($urandom_range(16, 2047));
            default: field = FIELD_W'($urandom);
        endcase
        pick  = $urandom_range(9);
        value = rand_bits($urandom_range(1, 64));
        case (kind)
            KIND_INT32, KIND_INT64: begin
                if (pick == 0)
                    value = rand_bits(1);
                else if (pick < 4)
                    value = -rand_bits($urandom_range(1, 63));
                if (kind == KIND_INT32)
                    value[63:32] = $urandom;
            end
            KIND_BOOL: begin
                if (pick < 4)
                    value = '0;
            end
            KIND_FLOAT: begin
                if (pick == 0)
                    value[31:0] = {value[31], 31'd0};
                else if (pick == 1)
                    value[31:0] = FLOAT_ONE_BITS;
                else
                    value[31:0] = $urandom;
                value[63:32] = $urandom;
            end
            KIND_DOUBLE: begin
                if (pick == 0)
                    value = {value[63], 63'd0};
                else if (pick == 1)
                    value = DOUBLE_ONE_BITS;
                else
                    value = {$urandom, $urandom};
            end
            default: value = {$urandom, $urandom};
        endcase
        add_item(kind, field, value);
    endtask

    // Waits until every issued item is taken, and optionally every byte is out
    task automatic wait_drained(input bit all_bytes);
        while (items_taken != items_issued || (all_bytes && expected_bytes.size() != 0))
            @(posedge aclk);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        @(posedge aclk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= stall_pct;
    endtask

    // Stimulus sequence
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, tag length boundaries, every kind and its special values
        add_item(KIND_INT32,  16'd0,      64'hFFFF_FFFF_0000_0000);
        add_item(KIND_INT32,  16'd15,     64'hA5A5_A5A5_0000_0001);
        add_item(KIND_INT32,  16'd16,     64'h0000_0000_FFFF_FFFF);
        add_item(KIND_INT32,  16'hFFFF,   64'h0000_0000_8000_0000);
        add_item(KIND_INT32,  16'd1,      64'hFFFF_FFFF_7FFF_FFFF);
        add_item(KIND_INT32,  16'd2047,   64'h0000_0000_0000_0080);
        add_item(KIND_INT64,  16'd2048,   64'd0);
        add_item(KIND_INT64,  16'd3,      64'd1);
        add_item(KIND_INT64,  16'hFFFF,   64'h8000_0000_0000_0000);
        add_item(KIND_INT64,  16'hFFFF,   64'h7FFF_FFFF_FFFF_FFFF);
        add_item(KIND_INT64,  16'd7,      64'hFFFF_FFFF_FFFF_FFFF);
        add_item(KIND_INT64,  16'd8,      64'd2);
        add_item(KIND_BOOL,   16'd9,      64'd0);
        add_item(KIND_BOOL,   16'hFFFF,   64'h8000_0000_0000_0000);
        add_item(KIND_FLOAT,  16'd10,     64'hFFFF_FFFF_0000_0000);
        add_item(KIND_FLOAT,  16'd11,     64'h0000_0000_8000_0000);
        add_item(KIND_FLOAT,  16'd12,     64'hFFFF_FFFF_3F80_0000);
        add_item(KIND_FLOAT,  16'hFFFF,   64'h0000_0000_7FC0_0000);
        add_item(KIND_DOUBLE, 16'd13,     64'h8000_0000_0000_0000);
        add_item(KIND_DOUBLE, 16'd14,     DOUBLE_ONE_BITS);
        add_item(KIND_DOUBLE, 16'hFFFF,   64'h7FF0_0000_0000_0000);
        add_item(KIND_DOUBLE, 16'd1,      64'hFFFF_FFFF_FFFF_FFFF);
        add_item(KIND_DOUBLE + 3'd1, 16'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(KIND_DOUBLE + 3'd2, 16'hFFFF, 64'd1);
        add_item('1,          16'd0,      64'd0);
        wait_drained(1'b0);

        // random, no idling on either side
        for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            add_random_item();
        wait_drained(1'b0);

        // sender mostly idle; then hold off until the output has fully drained
        set_idling(58, 0);
        for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            add_random_item();
        wait_drained(1'b1);

        // receiver stalling
        set_idling(0, 58);
        for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            add_random_item();
        wait_drained(1'b0);

        // both sides idle
        set_idling(27, 27);
        for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            add_random_item();
        wait_drained(1'b1);

        // let any stray bytes show up with the receiver always ready
        set_idling(0, 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* tagged_field_varint_encoder.f */
rtl/tfve_pkg.sv
rtl/tfve_classify.sv
rtl/tfve_queue.sv
rtl/tfve_serializer.sv
rtl/tagged_field_varint_encoder.sv
verif/tb_top.sv
